// File: hw/rtl/fbpa_pkg.sv
// shared types, codes and default sizes of the fixed block pool allocator
package fbpa_pkg;

  localparam int POOL_BLOCKS   = 32;
  localparam int PAYLOAD_BYTES = 128;
  localparam int HEADER_BYTES  = 4;

  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fl_ctrl_t;

endpackage

// File: hw/rtl/fixed_block_pool_allocator.sv
// top level of the fixed block pool allocator with a first in first out free list
//
// in channel: in_valid_i/in_ready_o carry operation_i (request or release)
// and block_address_i, the payload address to release.
// out channel: out_valid_o/out_ready_i carry status_o, granted_address_o and
// free_count_o, exactly one result beat for each input beat, in order.
// the result beat is registered, in the cycle after its input beat is accepted; one
// beat per cycle is sustained while out_ready_i is high, limited by the single pass
// through the release check multiplier and the prefetched free list memory head read.
// while a result waits on a stalled receiver the next input beat is accepted
// in the same cycle that the waiting result is taken; otherwise in_ready_o drops.
// configuration: cfg_we_i writes cfg_data_i to heap_base (index 0) or
// heap_limit (index 1) at once; write only while the block is idle.
// reset leaves every block free in address order with no clearing pass: a free
// list entry not yet written reads as its own position, tracked by the tail.
module fixed_block_pool_allocator #(
  parameter int POOL_BLOCKS   = fbpa_pkg::POOL_BLOCKS,
  parameter int PAYLOAD_BYTES = fbpa_pkg::PAYLOAD_BYTES,
  parameter int HEADER_BYTES  = fbpa_pkg::HEADER_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]     block_address_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fbpa_pkg::STATUS_W-1:0]   status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [fbpa_pkg::COUNT_W-1:0]    free_count_o
);

  localparam int AW     = fbpa_pkg::ADDR_W;
  localparam int IW     = $clog2(POOL_BLOCKS);
  localparam int CW     = $clog2(POOL_BLOCKS + 1);
  localparam int KW     = fbpa_pkg::COUNT_W;
  localparam int STRIDE = PAYLOAD_BYTES + HEADER_BYTES;

  logic [AW-1:0]      heap_base_q, heap_limit_q;
  logic               acc, is_req, empty, full, rel_ok;
  logic [IW-1:0]      rel_idx, head_idx;
  logic [CW-1:0]      count, count_next;
  logic [CW+KW-1:0]   count_ext;
  fbpa_pkg::fl_ctrl_t fl_ctrl;

  logic                    out_valid_q;
  fbpa_pkg::status_e       status_q, status_d;
  logic [AW-1:0]           granted_q, granted_d;
  logic [KW-1:0]           free_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_limit_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbpa_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data_i;
        fbpa_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fbpa_addr_chk #(
    .POOL_BLOCKS  (POOL_BLOCKS),
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_chk (
    .addr_i      (block_address_i),
    .heap_base_i (heap_base_q),
    .heap_limit_i(heap_limit_q),
    .ok_o        (rel_ok),
    .idx_o       (rel_idx)
  );

  fbpa_free_list #(
    .POOL_BLOCKS(POOL_BLOCKS)
  ) u_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fl_ctrl),
    .push_idx_i  (rel_idx),
    .head_idx_o  (head_idx),
    .count_o     (count),
    .count_next_o(count_next)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign is_req     = operation_i == fbpa_pkg::OP_REQUEST;
  assign empty      = count == '0;
  assign full       = count == CW'(POOL_BLOCKS);

  always_comb begin
    fl_ctrl.pop  = acc && is_req && !empty;
    fl_ctrl.push = acc && !is_req && rel_ok && !full;
    granted_d    = '0;
    if (is_req) begin
      status_d = empty ? fbpa_pkg::ST_EMPTY : fbpa_pkg::ST_OK;
      if (!empty) begin
        granted_d = heap_base_q + AW'(head_idx) * AW'(STRIDE) + AW'(HEADER_BYTES);
      end
    end else begin
      status_d = (rel_ok && !full) ? fbpa_pkg::ST_OK : fbpa_pkg::ST_INVALID;
    end
    count_ext = {{KW{1'b0}}, count_next};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q     <= status_d;
      granted_q    <= granted_d;
      free_count_q <= count_ext[KW-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign free_count_o      = free_count_q;

  a_acc_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted beat gave no result");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != fbpa_pkg::ST_OK)) |-> (granted_q == '0))
    else $error("address granted on a failed operation");

  a_pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_ctrl.pop |=> (count == $past(count) - CW'(1)))
    else $error("free count off after a grant");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(POOL_BLOCKS))
    else $error("free count above pool size");

endmodule

// File: hw/rtl/fbpa_free_list.sv
// circular free index list with prefetched head entry and reset fill by write count
module fbpa_free_list #(
  parameter int POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS,
  localparam int IW = $clog2(POOL_BLOCKS),
  localparam int CW = $clog2(POOL_BLOCKS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpa_pkg::fl_ctrl_t ctrl_i,
  input  logic [IW-1:0]      push_idx_i,
  output logic [IW-1:0]      head_idx_o,
  output logic [CW-1:0]      count_o,
  output logic [CW-1:0]      count_next_o
);

  localparam logic [IW-1:0] LAST = IW'(POOL_BLOCKS - 1);
  localparam logic [CW-1:0] FULL = CW'(POOL_BLOCKS);

  logic [IW-1:0] mem [POOL_BLOCKS];

  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic          wrapped_q, wrapped_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] rd_q;
  logic          byp_q, byp_d, wr_q, wr_d;
  logic [IW-1:0] byp_data_q;

  always_comb begin
    head_d = head_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LAST) ? '0 : head_q + IW'(1);
    end
    tail_d = tail_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == LAST) ? '0 : tail_q + IW'(1);
    end
    wrapped_d = wrapped_q | (ctrl_i.push & (tail_q == LAST));
    count_d = count_q;
    if (ctrl_i.pop) begin
      count_d = count_q - CW'(1);
    end else if (ctrl_i.push) begin
      count_d = count_q + CW'(1);
    end
    // entry at the next head already written, or being written now
    byp_d = ctrl_i.push & (tail_q == head_d);
    wr_d  = wrapped_q | (head_d < tail_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_idx_i;
    end
    rd_q <= mem[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      wrapped_q  <= 1'b0;
      count_q    <= FULL;
      byp_q      <= 1'b0;
      wr_q       <= 1'b0;
      byp_data_q <= '0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      wrapped_q  <= wrapped_d;
      count_q    <= count_d;
      byp_q      <= byp_d;
      wr_q       <= wr_d;
      byp_data_q <= push_idx_i;
    end
  end

  // never written entries are not read: the head position stands in as their index
  assign head_idx_o   = byp_q ? byp_data_q : (wr_q ? rd_q : head_q);
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

// File: hw/rtl/fbpa_addr_chk.sv
// release address check and conversion of a payload address to a block index
module fbpa_addr_chk #(
  parameter int POOL_BLOCKS   = fbpa_pkg::POOL_BLOCKS,
  parameter int PAYLOAD_BYTES = fbpa_pkg::PAYLOAD_BYTES,
  parameter int HEADER_BYTES  = fbpa_pkg::HEADER_BYTES,
  localparam int IW = $clog2(POOL_BLOCKS)
) (
  input  logic [fbpa_pkg::ADDR_W-1:0] addr_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] heap_base_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] heap_limit_i,
  output logic                        ok_o,
  output logic [IW-1:0]               idx_o
);

  localparam int AW     = fbpa_pkg::ADDR_W;
  localparam int STRIDE = PAYLOAD_BYTES + HEADER_BYTES;
  localparam int SPAN   = POOL_BLOCKS * STRIDE;
  localparam int N      = $clog2(SPAN);
  localparam int L      = $clog2(STRIDE);
  localparam int F      = N + L;
  localparam longint unsigned POW = 64'd1 << F;
  localparam longint unsigned C   = (POW + 64'(STRIDE) - 64'd1) / 64'(STRIDE);
  localparam int MW     = $clog2(C + 64'd1);
  localparam int PRODW  = N + MW;

  logic [AW-1:0]    hdr, off;
  logic [AW+1:0]    blk_end;
  logic             below_hdr, below_base, past_limit, in_span, rem_zero;
  logic [PRODW-1:0] prod;

  always_comb begin
    below_hdr  = addr_i < AW'(HEADER_BYTES);
    hdr        = addr_i - AW'(HEADER_BYTES);
    below_base = hdr < heap_base_i;
    blk_end    = {2'b00, hdr} + (AW+2)'(STRIDE);
    past_limit = blk_end > {2'b00, heap_limit_i};
    off        = hdr - heap_base_i;
    in_span    = off < AW'(SPAN);
    // multiply by rounded up reciprocal: quotient on top, exact when fraction below C
    prod       = PRODW'(off[N-1:0]) * PRODW'(C);
    rem_zero   = prod[F-1:0] < F'(C);
    idx_o      = IW'(prod >> F);
    ok_o       = (addr_i != '0) && !below_hdr && !below_base && !past_limit
                 && in_span && rem_zero;
  end

endmodule

// File: test/tb_fixed_block_pool_allocator.sv
// self-checking testbench for the fixed block pool allocator: directed table then random traffic
module tb_fixed_block_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned STRIDE = fbpa_pkg::PAYLOAD_BYTES + fbpa_pkg::HEADER_BYTES;
  localparam longint unsigned ADDR_MAX = 64'hFFFF_FFFF;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    fbpa_pkg::status_e           status;
    logic [fbpa_pkg::ADDR_W-1:0]  granted;
    logic [fbpa_pkg::COUNT_W-1:0] count;
  } pool_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_WINDOW
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    fbpa_pkg::op_e op;
    logic [31:0]   addr;
    logic [31:0]   limit;
    int            reps;
    bit            lit;
    pool_result_t  res;
  } plan_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             operation_i;
  logic [fbpa_pkg::ADDR_W-1:0]      block_address_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [fbpa_pkg::STATUS_W-1:0]    status_o;
  logic [fbpa_pkg::ADDR_W-1:0]      granted_address_o;
  logic [fbpa_pkg::COUNT_W-1:0]     free_count_o;

  fixed_block_pool_allocator uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .block_address_i   (block_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_count_o      (free_count_o)
  );

  // allocator state as the testbench sees it
  logic [31:0]     pool_base;
  logic [31:0]     pool_limit;
  int              free_ring [fbpa_pkg::POOL_BLOCKS];
  int              ring_head;
  int              ring_tail;
  int              ring_free;

  pool_result_t    outcome_q [$];
  logic [31:0]     granted_q [$];
  plan_row_t       plan_q [$];
  pool_result_t    exp_res;
  pool_result_t    got_res;
  bit              has_literal;
  pool_result_t    literal_res;
  longint unsigned win_base;
  bit              no_idle;
  int              fail_count;
  int              quiet_cycles;

  always #10 clk_i = ~clk_i;

  function automatic void pool_reset();
    pool_base  = '0;
    pool_limit = '1;
    for (int i = 0; i < fbpa_pkg::POOL_BLOCKS; i++) free_ring[i] = i;
    ring_head = 0;
    ring_tail = 0;
    ring_free = fbpa_pkg::POOL_BLOCKS;
  endfunction

  function automatic pool_result_t apply_pool_op(fbpa_pkg::op_e op, logic [31:0] addr);
    pool_result_t    res;
    longint unsigned a;
    longint unsigned hdr;
    longint unsigned off;
    longint unsigned slot;
    res.granted = '0;
    a = addr;
    if (op == fbpa_pkg::OP_REQUEST) begin
      if (ring_free == 0) begin
        res.status = fbpa_pkg::ST_EMPTY;
      end else begin
        slot = free_ring[ring_head];
        ring_head = (ring_head == fbpa_pkg::POOL_BLOCKS - 1) ? 0 : ring_head + 1;
        ring_free--;
        res.granted = 32'(longint'(pool_base) + slot * STRIDE + fbpa_pkg::HEADER_BYTES);
        res.status = fbpa_pkg::ST_OK;
      end
    end else begin
      res.status = fbpa_pkg::ST_INVALID;
      if (a != 0 && a >= fbpa_pkg::HEADER_BYTES) begin
        hdr = a - fbpa_pkg::HEADER_BYTES;
        if (hdr >= pool_base && hdr + STRIDE <= pool_limit) begin
          off = hdr - pool_base;
          if (off % STRIDE == 0 && off / STRIDE < fbpa_pkg::POOL_BLOCKS
              && ring_free < fbpa_pkg::POOL_BLOCKS) begin
            free_ring[ring_tail] = int'(off / STRIDE);
            ring_tail = (ring_tail == fbpa_pkg::POOL_BLOCKS - 1) ? 0 : ring_tail + 1;
            ring_free++;
            res.status = fbpa_pkg::ST_OK;
          end
        end
      end
    end
    res.count = fbpa_pkg::COUNT_W'(ring_free);
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_res = outcome_q.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_o);
            fail_count++;
          end
          if (granted_address_o !== exp_res.granted) begin
            $error("granted_address: expected 0x%08h, got 0x%08h", exp_res.granted,
                   granted_address_o);
            fail_count++;
          end
          if (free_count_o !== exp_res.count) begin
            $error("free_count: expected %0d, got %0d", exp_res.count, free_count_o);
            fail_count++;
          end
        end
        if (status_o == fbpa_pkg::ST_OK && granted_address_o != '0) begin
          granted_q.push_back(granted_address_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        got_res = apply_pool_op(fbpa_pkg::op_e'(operation_i), block_address_i);
        outcome_q.push_back(has_literal ? literal_res : got_res);
      end
      if (cfg_we_i) begin
        case (fbpa_pkg::cfg_idx_e'(cfg_idx_i))
          fbpa_pkg::CFG_HEAP_BASE:  pool_base = cfg_data_i;
          fbpa_pkg::CFG_HEAP_LIMIT: pool_limit = cfg_data_i;
          default: ;
        endcase
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pool_addr(int idx);
    return 32'(win_base + longint'(idx) * STRIDE + fbpa_pkg::HEADER_BYTES);
  endfunction

  task automatic send_beat(fbpa_pkg::op_e op, logic [31:0] addr, bit lit, pool_result_t lres);
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    block_address_i <= addr;
    has_literal     <= lit;
    literal_res     <= lres;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_window(logic [31:0] b, logic [31:0] l);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fbpa_pkg::CFG_HEAP_BASE;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_idx_i  <= fbpa_pkg::CFG_HEAP_LIMIT;
    cfg_data_i <= l;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    granted_q.delete();
    win_base = b;
  endtask

  task automatic add_item(fbpa_pkg::op_e op, logic [31:0] addr, int reps, bit lit,
                          fbpa_pkg::status_e st, logic [31:0] granted,
                          logic [fbpa_pkg::COUNT_W-1:0] count);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.addr  = addr;
    row.limit = '0;
    row.reps  = reps;
    row.lit   = lit;
    row.res   = '{st, granted, count};
    plan_q.push_back(row);
  endtask

  task automatic add_window(logic [31:0] b, logic [31:0] l);
    plan_row_t row;
    row.kind  = ROW_WINDOW;
    row.op    = fbpa_pkg::OP_REQUEST;
    row.addr  = b;
    row.limit = l;
    row.reps  = 0;
    row.lit   = 1'b0;
    row.res   = '0;
    plan_q.push_back(row);
  endtask

  initial begin
    int run;
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run - 1) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    int              r;
    int              idx;
    fbpa_pkg::op_e   op;
    logic [31:0]     a;
    longint unsigned b;
    longint unsigned l;
    plan_row_t       row;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = fbpa_pkg::CFG_HEAP_BASE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    operation_i     = fbpa_pkg::OP_REQUEST;
    block_address_i = '0;
    has_literal     = 1'b0;
    literal_res     = '0;
    win_base        = 0;
    no_idle         = 1'b0;
    fail_count      = 0;
    quiet_cycles    = 0;
    pool_reset();

    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_OK, 32'd4, 6'd31);
    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_OK, 32'd136, 6'd30);
    add_item(fbpa_pkg::OP_RELEASE, 32'h0, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd30);
    add_item(fbpa_pkg::OP_RELEASE, 32'd3, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd30);
    add_item(fbpa_pkg::OP_RELEASE, 32'd5, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd30);
    add_item(fbpa_pkg::OP_RELEASE, 32'd4228, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd30);
    add_item(fbpa_pkg::OP_RELEASE, 32'hFFFF_FFFF, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd30);
    add_item(fbpa_pkg::OP_RELEASE, 32'd4, 1, 1'b1, fbpa_pkg::ST_OK, 32'h0, 6'd31);
    add_item(fbpa_pkg::OP_RELEASE, 32'd136, 1, 1'b1, fbpa_pkg::ST_OK, 32'h0, 6'd32);
    add_item(fbpa_pkg::OP_RELEASE, 32'd4, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd32);
    add_item(fbpa_pkg::OP_REQUEST, 32'hFFFF_FFFF, 32, 1'b0, fbpa_pkg::ST_OK, 32'h0, 6'd0);
    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_EMPTY, 32'h0, 6'd0);
    add_item(fbpa_pkg::OP_RELEASE, 32'd4, 1, 1'b1, fbpa_pkg::ST_OK, 32'h0, 6'd1);
    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_OK, 32'd4, 6'd0);
    add_window(32'h0000_1000, 32'h0000_1210);
    add_item(fbpa_pkg::OP_RELEASE, 32'h0000_1000, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd0);
    add_item(fbpa_pkg::OP_RELEASE, 32'h0000_1190, 1, 1'b1, fbpa_pkg::ST_OK, 32'h0, 6'd1);
    add_item(fbpa_pkg::OP_RELEASE, 32'h0000_1214, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd1);
    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_OK, 32'h0000_1190, 6'd0);
    add_window(32'hFFFF_FFFF, 32'h0);
    add_item(fbpa_pkg::OP_RELEASE, 32'd4, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd0);
    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_EMPTY, 32'h0, 6'd0);
    add_window(32'hFFFF_FF00, 32'hFFFF_FFFF);
    add_item(fbpa_pkg::OP_RELEASE, 32'hFFFF_FF04, 1, 1'b1, fbpa_pkg::ST_OK, 32'h0, 6'd1);
    add_item(fbpa_pkg::OP_RELEASE, 32'h0000_000C, 1, 1'b1, fbpa_pkg::ST_INVALID, 32'h0, 6'd1);
    add_item(fbpa_pkg::OP_REQUEST, 32'h0, 1, 1'b1, fbpa_pkg::ST_OK, 32'hFFFF_FF04, 6'd0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_WINDOW) begin
        set_window(row.addr, row.limit);
      end else begin
        repeat (row.reps) begin
          send_beat(row.op, row.addr, row.lit, row.res);
          pause(pick_gap());
        end
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      r = (ph == 0) ? 0 : $urandom_range(0, 5);
      case (r)
        0: begin
          b = 0;
          l = ADDR_MAX;
        end
        1: begin
          b = $urandom_range(0, 32'h00FF_FFFF);
          l = ADDR_MAX;
        end
        2: begin
          b = $urandom;
          l = b + $urandom_range(0, fbpa_pkg::POOL_BLOCKS) * STRIDE;
          if (l > ADDR_MAX) l = ADDR_MAX;
        end
        3: begin
          b = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'hFFFF_F800;
          l = ADDR_MAX;
        end
        4: begin
          b = $urandom;
          l = $urandom;
        end
        default: begin
          b = 0;
          l = 0;
        end
      endcase
      set_window(32'(b), 32'(l));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        r = $urandom_range(0, 99);
        op = fbpa_pkg::OP_RELEASE;
        if (r < 45) begin
          op = fbpa_pkg::OP_REQUEST;
          a = $urandom;
        end else if (r < 75 && granted_q.size() > 0) begin
          idx = $urandom_range(0, granted_q.size() - 1);
          a = granted_q[idx];
          granted_q.delete(idx);
        end else if (r < 88) begin
          a = pool_addr($urandom_range(0, fbpa_pkg::POOL_BLOCKS - 1));
        end else if (r < 94) begin
          a = pool_addr($urandom_range(0, fbpa_pkg::POOL_BLOCKS + 7));
          if ($urandom_range(0, 1) == 1) a = a + $urandom_range(1, STRIDE - 1);
        end else begin
          a = $urandom;
        end
        send_beat(op, a, 1'b0, '0);
        pause(pick_gap());
      end
    end

    drain();
    repeat (5) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_free_list.sv
hw/rtl/fbpa_addr_chk.sv
hw/rtl/fixed_block_pool_allocator.sv
test/tb_fixed_block_pool_allocator.sv
